// ===== hdl/slx_pkg.sv =====
// Shared types, character codes and result builders for the token lexer.
// No dependencies; every other file but slx_if imports this package.
`timescale 1ns / 1ps

package slx_pkg;

   localparam int unsigned BATCH_DEPTH = 3;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [1:0] KIND_PAREN  = 2'd0;
   localparam logic [1:0] KIND_STRING = 2'd1;
   localparam logic [1:0] KIND_NUMBER = 2'd2;
   localparam logic [1:0] KIND_SYMBOL = 2'd3;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_MINUSDOT = 2'd1;
   localparam logic [1:0] ERR_UNTERM   = 2'd2;

   typedef enum logic [5:0] {
      MODE_IDLE = 6'b000001,
      MODE_STR  = 6'b000010,
      MODE_ESC  = 6'b000100,
      MODE_NUM  = 6'b001000,
      MODE_SYM  = 6'b010000,
      MODE_DROP = 6'b100000
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       is_byte;
      logic       token_start;
      logic [1:0] token_kind;
      logic [1:0] error_code;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      result_type [BATCH_DEPTH-1:0] res;
      logic [1:0]                   cnt;
   } batch_type;

   function automatic result_type mk_byte(input logic [7:0] c, input logic start);
      result_type r;
      r             = '0;
      r.token_byte  = c;
      r.is_byte     = 1'b1;
      r.token_start = start;
      return r;
   endfunction

   function automatic result_type mk_close(input logic [1:0] kind, input logic [1:0] err);
      result_type r;
      r            = '0;
      r.token_kind = kind;
      r.error_code = err;
      return r;
   endfunction

endpackage

// ===== hdl/slx_if.sv =====
// Valid/ready channel interfaces for character items and token result items.
// No dependencies.
`timescale 1ns / 1ps

interface slx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       text_end;

   modport source (output valid, output char_byte, output text_end, input ready);
   modport sink   (input valid, input char_byte, input text_end, output ready);
endinterface

interface slx_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] token_byte;
   logic       is_byte;
   logic       token_start;
   logic [1:0] token_kind;
   logic [1:0] error_code;
   logic       last_of_run;

   modport source (output valid, output token_byte, output is_byte, output token_start,
                   output token_kind, output error_code, output last_of_run, input ready);
   modport sink   (input valid, input token_byte, input is_byte, input token_start,
                   input token_kind, input error_code, input last_of_run, output ready);
endinterface

// ===== hdl/slx_lexer.sv =====
// Lexer mode state and the per-character step that builds a batch of up to three results.
// Depends on slx_pkg.
`timescale 1ns / 1ps

module slx_lexer (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [7:0]        char_byte,
   input  logic              text_end,
   output slx_pkg::batch_type batch,
   output logic              dropping
);
   import slx_pkg::*;

   lex_mode_type mode_ff, mode_in;
   logic         minus_ff, minus_in;

   logic is_space, is_paren, is_digit, is_sep_sym, go_open;

   assign is_space   = (char_byte == CH_SPACE) || (char_byte == CH_TAB) || (char_byte == CH_NL);
   assign is_paren   = (char_byte == CH_LPAREN) || (char_byte == CH_RPAREN);
   assign is_digit   = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
   assign is_sep_sym = is_space || is_paren || (char_byte == CH_QUOTE);
   assign dropping   = (mode_ff == MODE_DROP);

   always_comb begin
      batch    = '0;
      mode_in  = mode_ff;
      minus_in = minus_ff;
      go_open  = 1'b0;

      case (mode_ff)
         MODE_IDLE: begin
            go_open = 1'b1;
         end
         MODE_STR: begin
            batch.res[batch.cnt] = mk_byte(char_byte, 1'b0);
            batch.cnt            = batch.cnt + 2'd1;
            if (char_byte == CH_BSLASH) begin
               mode_in = MODE_ESC;
            end else if (char_byte == CH_QUOTE) begin
               batch.res[batch.cnt] = mk_close(KIND_STRING, ERR_NONE);
               batch.cnt            = batch.cnt + 2'd1;
               mode_in              = MODE_IDLE;
            end
         end
         MODE_ESC: begin
            batch.res[batch.cnt] = mk_byte(char_byte, 1'b0);
            batch.cnt            = batch.cnt + 2'd1;
            mode_in              = MODE_STR;
         end
         MODE_NUM: begin
            if (minus_ff && (char_byte == CH_DOT)) begin
               batch.res[batch.cnt] = mk_close(KIND_NUMBER, ERR_MINUSDOT);
               batch.cnt            = batch.cnt + 2'd1;
               mode_in              = MODE_DROP;
               minus_in             = 1'b0;
            end else if (is_space || is_paren) begin
               batch.res[batch.cnt] = mk_close(minus_ff ? KIND_SYMBOL : KIND_NUMBER, ERR_NONE);
               batch.cnt            = batch.cnt + 2'd1;
               mode_in              = MODE_IDLE;
               minus_in             = 1'b0;
               go_open              = 1'b1;
            end else begin
               batch.res[batch.cnt] = mk_byte(char_byte, 1'b0);
               batch.cnt            = batch.cnt + 2'd1;
               minus_in             = 1'b0;
            end
         end
         MODE_SYM: begin
            if (is_sep_sym) begin
               batch.res[batch.cnt] = mk_close(KIND_SYMBOL, ERR_NONE);
               batch.cnt            = batch.cnt + 2'd1;
               mode_in              = MODE_IDLE;
               go_open              = 1'b1;
            end else begin
               batch.res[batch.cnt] = mk_byte(char_byte, 1'b0);
               batch.cnt            = batch.cnt + 2'd1;
            end
         end
         default: begin
         end
      endcase

      if (go_open && !is_space) begin
         batch.res[batch.cnt] = mk_byte(char_byte, 1'b1);
         batch.cnt            = batch.cnt + 2'd1;
         if (is_paren) begin
            batch.res[batch.cnt] = mk_close(KIND_PAREN, ERR_NONE);
            batch.cnt            = batch.cnt + 2'd1;
            mode_in              = MODE_IDLE;
         end else if (char_byte == CH_QUOTE) begin
            mode_in = MODE_STR;
         end else if (is_digit) begin
            mode_in  = MODE_NUM;
            minus_in = 1'b0;
         end else if (char_byte == CH_MINUS) begin
            mode_in  = MODE_NUM;
            minus_in = 1'b1;
         end else begin
            mode_in = MODE_SYM;
         end
      end

      // close any open token at the end of the text
      if (text_end) begin
         if ((mode_in == MODE_STR) || (mode_in == MODE_ESC)) begin
            batch.res[batch.cnt] = mk_close(KIND_STRING, ERR_UNTERM);
            batch.cnt            = batch.cnt + 2'd1;
         end else if (mode_in == MODE_NUM) begin
            batch.res[batch.cnt] = mk_close(minus_in ? KIND_SYMBOL : KIND_NUMBER, ERR_NONE);
            batch.cnt            = batch.cnt + 2'd1;
         end else if (mode_in == MODE_SYM) begin
            batch.res[batch.cnt] = mk_close(KIND_SYMBOL, ERR_NONE);
            batch.cnt            = batch.cnt + 2'd1;
         end
         mode_in  = MODE_IDLE;
         minus_in = 1'b0;
      end

      if (batch.cnt != 2'd0) begin
         batch.res[batch.cnt - 2'd1].last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         minus_ff <= 1'b0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         minus_ff <= minus_in;
      end
   end

endmodule

// ===== hdl/slx_emit.sv =====
// Result register: holds one batch of up to three results and hands them out in order.
// Depends on slx_pkg.
`timescale 1ns / 1ps

module slx_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  slx_pkg::batch_type batch,
   input  logic               pop,
   output logic               free,
   output logic               head_valid,
   output slx_pkg::result_type head
);
   import slx_pkg::*;

   result_type [BATCH_DEPTH-1:0] slots_ff, slots_in;
   logic [1:0]                   cnt_ff, cnt_in;

   assign head_valid = (cnt_ff != 2'd0);
   assign head       = slots_ff[0];
   assign free       = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);

   always_comb begin
      slots_in = slots_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         slots_in = batch.res;
         cnt_in   = batch.cnt;
      end else if (pop) begin
         // advance the queue by one item
         for (int i = 0; i < BATCH_DEPTH - 1; i++) begin
            slots_in[i] = slots_ff[i + 1];
         end
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

endmodule

// ===== hdl/scheme_token_lexer_unit.sv =====
// Top level of the token lexer: input register, lexer step and result register.
// Depends on slx_pkg, slx_if, slx_lexer and slx_emit.
//
//   channel   direction   item contents
//   req_if    in          char_byte, text_end
//   rsp_if    out         token_byte, is_byte, token_start, token_kind, error_code,
//                         last_of_run
//
// One character item is taken per cycle while each yields at most one result
// and the output is not stalled. A character with n results (n up to 3) holds
// the result register until all n have left through the single output port;
// a character with no result does not occupy it. Reset clears the lexer mode and
// the input and result occupancy. A stalled output backs up into req_if.ready
// through the result register.
`timescale 1ns / 1ps

module scheme_token_lexer_unit (
   input logic     clock,
   input logic     reset,
   slx_req_if.sink   req_if,
   slx_rsp_if.source rsp_if
);
   import slx_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_char_ff;
   logic       in_end_ff;

   logic       load, emit_free, pop, req_take, dropping;
   batch_type  batch;
   result_type head;

   assign pop         = rsp_if.valid && rsp_if.ready;
   assign load        = in_vld_ff && emit_free;
   assign req_if.ready = !in_vld_ff || load;
   assign req_take    = req_if.valid && req_if.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (load) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_if.char_byte;
         in_end_ff  <= req_if.text_end;
      end
   end

   slx_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .advance   (load),
      .char_byte (in_char_ff),
      .text_end  (in_end_ff),
      .batch     (batch),
      .dropping  (dropping)
   );

   slx_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .batch      (batch),
      .pop        (pop),
      .free       (emit_free),
      .head_valid (rsp_if.valid),
      .head       (head)
   );

   assign rsp_if.token_byte  = head.token_byte;
   assign rsp_if.is_byte     = head.is_byte;
   assign rsp_if.token_start = head.token_start;
   assign rsp_if.token_kind  = head.token_kind;
   assign rsp_if.error_code  = head.error_code;
   assign rsp_if.last_of_run = head.last_of_run;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(req_take && in_vld_ff && !load))
      else $error("input register overwritten while holding an item");

   a_marker_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.is_byte) |-> (!rsp_if.token_start && rsp_if.token_byte == 8'h00))
      else $error("close marker carries byte fields");

   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && dropping) |-> (batch.cnt == 2'd0))
      else $error("result produced while dropping after an error");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (pop && !rsp_if.last_of_run) |=> rsp_if.valid)
      else $error("run ended without its final result");

endmodule

// ===== verif/slx_token_checker.sv =====
// Token checker for scheme_token_lexer_unit: watches both channels, predicts the
// token items of each accepted character and compares them in order.
// Depends on slx_pkg and slx_if.
`timescale 1ns / 1ps

module slx_token_checker (
   input  logic clock,
   input  logic reset,
   slx_req_if   req,
   slx_rsp_if   rsp,
   output int   fail_count,
   output int   outstanding
);
   import slx_pkg::*;

   lex_mode_type mode;
   logic         minus_only;
   result_type   token_q[$];
   result_type   char_results[$];

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NL;
   endfunction

   function automatic logic is_paren(input logic [7:0] c);
      return c == CH_LPAREN || c == CH_RPAREN;
   endfunction

   task automatic add_byte(input logic [7:0] c, input logic start);
      result_type r;
      r             = '0;
      r.token_byte  = c;
      r.is_byte     = 1'b1;
      r.token_start = start;
      char_results.push_back(r);
   endtask

   task automatic add_close(input logic [1:0] kind, input logic [1:0] err);
      result_type r;
      r            = '0;
      r.token_kind = kind;
      r.error_code = err;
      char_results.push_back(r);
   endtask

   task automatic open_token(input logic [7:0] c);
      if (!is_blank(c)) begin
         add_byte(c, 1'b1);
         if (is_paren(c)) begin
            add_close(KIND_PAREN, ERR_NONE);
            mode = MODE_IDLE;
         end else if (c == CH_QUOTE) begin
            mode = MODE_STR;
         end else if (c >= CH_ZERO && c <= CH_NINE) begin
            mode       = MODE_NUM;
            minus_only = 1'b0;
         end else if (c == CH_MINUS) begin
            mode       = MODE_NUM;
            minus_only = 1'b1;
         end else begin
            mode = MODE_SYM;
         end
      end
   endtask

   task automatic predict_tokens(input logic [7:0] c, input logic text_end);
      result_type r;
      char_results.delete();
      case (mode)
         MODE_IDLE: begin
            open_token(c);
         end
         MODE_STR: begin
            add_byte(c, 1'b0);
            if (c == CH_BSLASH) begin
               mode = MODE_ESC;
            end else if (c == CH_QUOTE) begin
               add_close(KIND_STRING, ERR_NONE);
               mode = MODE_IDLE;
            end
         end
         MODE_ESC: begin
            add_byte(c, 1'b0);
            mode = MODE_STR;
         end
         MODE_NUM: begin
            if (minus_only && c == CH_DOT) begin
               add_close(KIND_NUMBER, ERR_MINUSDOT);
               mode       = MODE_DROP;
               minus_only = 1'b0;
            end else if (is_blank(c) || is_paren(c)) begin
               add_close(minus_only ? KIND_SYMBOL : KIND_NUMBER, ERR_NONE);
               mode       = MODE_IDLE;
               minus_only = 1'b0;
               open_token(c);
            end else begin
               add_byte(c, 1'b0);
               minus_only = 1'b0;
            end
         end
         MODE_SYM: begin
            if (is_blank(c) || is_paren(c) || c == CH_QUOTE) begin
               add_close(KIND_SYMBOL, ERR_NONE);
               mode = MODE_IDLE;
               open_token(c);
            end else begin
               add_byte(c, 1'b0);
            end
         end
         default: begin
         end
      endcase

      if (text_end) begin
         if (mode == MODE_STR || mode == MODE_ESC)
            add_close(KIND_STRING, ERR_UNTERM);
         else if (mode == MODE_NUM)
            add_close(minus_only ? KIND_SYMBOL : KIND_NUMBER, ERR_NONE);
         else if (mode == MODE_SYM)
            add_close(KIND_SYMBOL, ERR_NONE);
         mode       = MODE_IDLE;
         minus_only = 1'b0;
      end

      if (char_results.size() > 0) begin
         r             = char_results.pop_back();
         r.last_of_run = 1'b1;
         char_results.push_back(r);
      end
      foreach (char_results[i])
         token_q.push_back(char_results[i]);
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         mode       = MODE_IDLE;
         minus_only = 1'b0;
         token_q.delete();
         fail_count = 0;
      end else begin
         if (req.valid && req.ready)
            predict_tokens(req.char_byte, req.text_end);
         if (rsp.valid && rsp.ready) begin
            got             = '0;
            got.token_byte  = rsp.token_byte;
            got.is_byte     = rsp.is_byte;
            got.token_start = rsp.token_start;
            got.token_kind  = rsp.token_kind;
            got.error_code  = rsp.error_code;
            got.last_of_run = rsp.last_of_run;
            if (token_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected token item byte=%h isb=%b start=%b %s%0d %s%0d last=%b",
                           $realtime, got.token_byte, got.is_byte, got.token_start,
                           "kind=", got.token_kind, "err=", got.error_code,
                           got.last_of_run);
               fail_count = fail_count + 1;
            end else begin
               want = token_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("%0t: token mismatch exp byte=%h isb=%b start=%b kind=%0d",
                              $realtime, want.token_byte, want.is_byte, want.token_start,
                              want.token_kind);
                     $display("   exp err=%0d last=%b", want.error_code, want.last_of_run);
                     $display("   got byte=%h isb=%b start=%b kind=%0d err=%0d last=%b",
                              got.token_byte, got.is_byte, got.token_start,
                              got.token_kind, got.error_code, got.last_of_run);
                  end
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      outstanding <= token_q.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for scheme_token_lexer_unit: drives character texts with random
// idling on both channels and gives the verdict from slx_token_checker.
// Depends on slx_pkg, slx_if, slx_token_checker and the lexer RTL.
`timescale 1ns / 1ps

module tb_top;
   import slx_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   chars_sent;
   int   stall_left;
   bit   gaps_on;
   bit   stalls_on;
   bit   drained_once;
   logic [7:0] text_q[$];

   slx_req_if req_bus ();
   slx_rsp_if rsp_bus ();

   scheme_token_lexer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   slx_token_checker token_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #200000;
      $display("scheme_token_lexer_unit test failed");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         stall_left     = 0;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left     = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
         stall_left     = $urandom_range(0, 3);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // enter and leave at a falling edge; valid stays high after the item
   task automatic send_char(input logic [7:0] c, input logic last);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.char_byte <= c;
      req_bus.text_end  <= last;
      @(posedge clock);
      while (!(req_bus.valid && req_bus.ready)) @(posedge clock);
      chars_sent = chars_sent + 1;
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_q[i])
         send_char(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 2))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         default: return CH_NL;
      endcase
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_LPAREN ||
             c == CH_RPAREN || c == CH_QUOTE)
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic add_token();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1: begin
            text_q.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
         end
         2, 3: begin
            text_q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 5)) begin
               if ($urandom_range(0, 4) == 0) begin
                  text_q.push_back(CH_BSLASH);
                  c = 8'($urandom_range(0, 255));
                  text_q.push_back(c);
               end else begin
                  c = 8'($urandom_range(0, 255));
                  while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
                  text_q.push_back(c);
               end
            end
            text_q.push_back(CH_QUOTE);
         end
         4, 5: begin
            if ($urandom_range(0, 2) == 0) text_q.push_back(CH_MINUS);
            repeat ($urandom_range(1, 4)) begin
               c = CH_ZERO + 8'($urandom_range(0, 9));
               text_q.push_back(c);
            end
            if ($urandom_range(0, 5) == 0) text_q.push_back(plain_char());
         end
         6, 7: begin
            repeat ($urandom_range(1, 4)) text_q.push_back(plain_char());
         end
         8: begin
            text_q.push_back(CH_MINUS);
         end
         default: begin
            text_q.push_back(CH_MINUS);
            text_q.push_back(CH_DOT);
            repeat ($urandom_range(0, 3)) begin
               c = 8'($urandom_range(0, 255));
               text_q.push_back(c);
            end
         end
      endcase
   endtask

   task automatic build_text();
      logic [7:0] c;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 8)) begin
            c = 8'($urandom_range(0, 255));
            text_q.push_back(c);
         end
      end else begin
         if ($urandom_range(0, 3) == 0) text_q.push_back(blank_char());
         repeat ($urandom_range(1, 6)) begin
            add_token();
            if ($urandom_range(0, 2) != 0)
               repeat ($urandom_range(1, 2)) text_q.push_back(blank_char());
         end
         // drop the last character, which may leave a token open
         if ($urandom_range(0, 5) == 0 && text_q.size() > 1) void'(text_q.pop_back());
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.char_byte = 8'h00;
      req_bus.text_end  = 1'b0;
      chars_sent        = 0;
      gaps_on           = 1'b1;
      stalls_on         = 1'b1;
      drained_once      = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_str("(-7 -)");
      send_text();
      push_str("\"x\\\"\"");
      send_text();
      push_str("-.z");
      send_text();
      push_str("ab\"c");
      send_text();
      push_str("\"\\");
      send_text();
      push_str("-");
      send_text();
      text_q.push_back(8'h00);
      text_q.push_back(8'hFF);
      text_q.push_back(CH_TAB);
      text_q.push_back(CH_NL);
      text_q.push_back(CH_NINE);
      send_text();

      while (chars_sent < 410) begin
         if (chars_sent >= 350) begin
            gaps_on    = 1'b0;
            stalls_on <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            gaps_on    = 1'b0;
            stalls_on <= 1'b0;
         end else begin
            gaps_on    = 1'b1;
            stalls_on <= 1'b1;
         end
         if (!drained_once && chars_sent >= 200) begin
            // hold until every pending token item has come out
            drained_once   = 1'b1;
            req_bus.valid <= 1'b0;
            @(negedge clock);
            while (outstanding != 0) @(negedge clock);
         end
         build_text();
         send_text();
      end

      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("scheme_token_lexer_unit test passed");
      else
         $display("scheme_token_lexer_unit test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/slx_pkg.sv
hdl/slx_if.sv
hdl/slx_lexer.sv
hdl/slx_emit.sv
hdl/scheme_token_lexer_unit.sv
verif/slx_token_checker.sv
verif/tb_top.sv
